FILE: design/srle_pkg.sv
// ----------------------------------------------------------------------------
// srle_pkg
// types, codes and the zone table shared by the track decoder modules
// ----------------------------------------------------------------------------
package srle_pkg;

  typedef enum logic [3:0] {
    PH_HDR0 = 4'd0,
    PH_HDR1 = 4'd1,
    PH_COPY = 4'd2,
    PH_FILL = 4'd3,
    PH_RLEN = 4'd4,
    PH_RESC = 4'd5,
    PH_RDAT = 4'd6,
    PH_RCNT = 4'd7,
    PH_RVAL = 4'd8
  } phase_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_MODE = 2'd1;
  localparam logic [1:0] ST_BAD_TRK  = 2'd2;
  localparam logic [1:0] ST_OVERRUN  = 2'd3;

  localparam logic [1:0] MODE_COPY = 2'd0;
  localparam logic [1:0] MODE_FILL = 2'd1;
  localparam logic [1:0] MODE_BAD  = 2'd3;

  localparam logic [8:0] SECTOR_BYTES = 9'd256;
  localparam logic [8:0] LAST_OFFSET  = 9'd255;

  typedef struct packed {
    logic       vld;
    logic [7:0] data;
  } byte_beat_t;

  typedef struct packed {
    logic [5:0] track_num;
    logic [7:0] sector_num;
    logic [7:0] start_offset;
    logic [7:0] fill_value;
    logic [8:0] run_length;
    logic       sector_end;
    logic       track_end;
    logic [1:0] status;
  } res_t;

  function automatic logic [4:0] zone_sectors(input logic [5:0] trk);
    logic [4:0] n;
    if (trk <= 6'd17)      n = 5'd21;
    else if (trk <= 6'd24) n = 5'd19;
    else if (trk <= 6'd30) n = 5'd18;
    else                   n = 5'd17;
    return n;
  endfunction

endpackage

FILE: design/srle_ifs.sv
// ----------------------------------------------------------------------------
// srle_ifs
// valid/ready channels for packed bytes in and decoded runs out
// ----------------------------------------------------------------------------
interface srle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface srle_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] track_num;
  logic [7:0] sector_num;
  logic [7:0] start_offset;
  logic [7:0] fill_value;
  logic [8:0] run_length;
  logic       sector_end;
  logic       track_end;
  logic [1:0] status;

  modport source (output valid, output track_num, output sector_num, output start_offset,
                  output fill_value, output run_length, output sector_end,
                  output track_end, output status, input ready);
  modport sink   (input valid, input track_num, input sector_num, input start_offset,
                  input fill_value, input run_length, input sector_end,
                  input track_end, input status, output ready);
endinterface

FILE: design/sector_rle_track_decoder_top.sv
// ----------------------------------------------------------------------------
// sector_rle_track_decoder_top
// packed disk-track decoder: one byte in, at most one run out per byte
//
// path: a byte taken from in_bus passes the input register, then the result register, before its run shows on out_bus
// throughput: one byte per cycle while the result register can advance; the decode step
// between the input register and the result register is combinational
// reset: synchronous active-low rst_n clears all control state (data registers are not reset), no clearing pass
// ----------------------------------------------------------------------------
module sector_rle_track_decoder_top
  import srle_pkg::*;
#(
  parameter int MAX_TRACK = 35
) (
  input  logic              clk,
  input  logic              rst_n,
  srle_in_if.sink           in_bus,
  srle_out_if.source        out_bus
);

  byte_beat_t beat;
  logic       advance;
  res_t       res;
  logic       res_vld;
  res_t       out_res;

  srle_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_bus.ready),
    .in_data  (in_bus.data_byte),
    .advance  (advance),
    .beat     (beat)
  );

  srle_core #(
    .MAX_TRACK (MAX_TRACK)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .beat    (beat),
    .advance (advance),
    .res     (res),
    .res_vld (res_vld)
  );

  srle_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .res_vld   (res_vld),
    .advance   (advance),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .out_res   (out_res)
  );

  assign out_bus.track_num    = out_res.track_num;
  assign out_bus.sector_num   = out_res.sector_num;
  assign out_bus.start_offset = out_res.start_offset;
  assign out_bus.fill_value   = out_res.fill_value;
  assign out_bus.run_length   = out_res.run_length;
  assign out_bus.sector_end   = out_res.sector_end;
  assign out_bus.track_end    = out_res.track_end;
  assign out_bus.status       = out_res.status;

endmodule

FILE: design/srle_in_stage.sv
// ----------------------------------------------------------------------------
// srle_in_stage
// input register holding one packed byte for the decode step
// ----------------------------------------------------------------------------
module srle_in_stage
  import srle_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [7:0]   in_data,
  input  logic         advance,
  output byte_beat_t   beat
);

  logic       vld_r;
  logic       vld_nxt;
  logic [7:0] data_r;

  assign in_ready = !vld_r || advance;

  always_comb begin
    vld_nxt = vld_r;
    if (in_ready) begin
      vld_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

  assign beat.vld  = vld_r;
  assign beat.data = data_r;

endmodule

FILE: design/srle_core.sv
// ----------------------------------------------------------------------------
// srle_core
// decoder state and the per-byte step: headers, copy, fill and escape runs
// ----------------------------------------------------------------------------
module srle_core
  import srle_pkg::*;
#(
  parameter int MAX_TRACK = 35
) (
  input  logic       clk,
  input  logic       rst_n,
  input  byte_beat_t beat,
  input  logic       advance,
  output res_t       res,
  output logic       res_vld
);

  localparam logic [5:0] MaxTrk = 6'(MAX_TRACK);

  phase_t     phase_r, phase_nxt;
  logic [1:0] mode_r, mode_nxt;
  logic [5:0] track_r, track_nxt;
  logic [7:0] sector_r, sector_nxt;
  logic [4:0] left_r, left_nxt;
  logic [8:0] woff_r, woff_nxt;
  logic [7:0] coded_r, coded_nxt;
  logic [7:0] esc_r, esc_nxt;
  logic [7:0] rep_r, rep_nxt;
  logic       halted_r, halted_nxt;

  logic       fire;
  logic [7:0] b;
  logic [4:0] left_fin;
  logic       te_fin;
  logic [9:0] rep_end;
  logic [7:0] coded_dec;
  logic [7:0] coded_sub3;

  assign fire       = beat.vld && advance;
  assign b          = beat.data;
  assign left_fin   = (left_r != 5'd0) ? left_r - 5'd1 : left_r;
  assign te_fin     = (left_fin == 5'd0);
  assign rep_end    = {1'b0, woff_r} + {2'b00, rep_r};
  assign coded_dec  = coded_r - 8'd1;
  assign coded_sub3 = (coded_r >= 8'd3) ? coded_r - 8'd3 : 8'd0;

  always_comb begin
    phase_nxt  = phase_r;
    mode_nxt   = mode_r;
    track_nxt  = track_r;
    sector_nxt = sector_r;
    left_nxt   = left_r;
    woff_nxt   = woff_r;
    coded_nxt  = coded_r;
    esc_nxt    = esc_r;
    rep_nxt    = rep_r;
    halted_nxt = halted_r;
    res_vld    = 1'b0;
    res.track_num    = track_r;
    res.sector_num   = sector_r;
    res.start_offset = woff_r[7:0];
    res.fill_value   = b;
    res.run_length   = 9'd1;
    res.sector_end   = 1'b0;
    res.track_end    = 1'b0;
    res.status       = ST_OK;
    if (fire && !halted_r) begin
      case (phase_r)
        PH_HDR0: begin
          mode_nxt  = b[7:6];
          track_nxt = b[5:0];
          phase_nxt = PH_HDR1;
        end
        PH_HDR1: begin
          sector_nxt       = b;
          res.sector_num   = b;
          res.start_offset = 8'd0;
          res.fill_value   = 8'd0;
          res.run_length   = 9'd0;
          if (mode_r == MODE_BAD) begin
            res.status = ST_BAD_MODE;
            res_vld    = 1'b1;
            halted_nxt = 1'b1;
          end else if (left_r == 5'd0 && (track_r == 6'd0 || track_r > MaxTrk)) begin
            res.status = ST_BAD_TRK;
            res_vld    = 1'b1;
            halted_nxt = 1'b1;
          end else begin
            if (left_r == 5'd0) begin
              left_nxt = zone_sectors(track_r);
            end
            woff_nxt = 9'd0;
            case (mode_r)
              MODE_COPY: phase_nxt = PH_COPY;
              MODE_FILL: phase_nxt = PH_FILL;
              default:   phase_nxt = PH_RLEN;
            endcase
          end
        end
        PH_COPY: begin
          res_vld = 1'b1;
          if (woff_r >= LAST_OFFSET) begin
            phase_nxt        = PH_HDR0;
            left_nxt         = left_fin;
            res.start_offset = LAST_OFFSET[7:0];
            res.sector_end   = 1'b1;
            res.track_end    = te_fin;
            woff_nxt         = SECTOR_BYTES;
          end else begin
            woff_nxt = woff_r + 9'd1;
          end
        end
        PH_FILL: begin
          res_vld          = 1'b1;
          phase_nxt        = PH_HDR0;
          left_nxt         = left_fin;
          res.start_offset = 8'd0;
          res.run_length   = SECTOR_BYTES;
          res.sector_end   = 1'b1;
          res.track_end    = te_fin;
          woff_nxt         = SECTOR_BYTES;
        end
        PH_RLEN: begin
          coded_nxt = b;
          phase_nxt = PH_RESC;
        end
        PH_RESC: begin
          esc_nxt = b;
          if (coded_r == 8'd0) begin
            phase_nxt = PH_HDR0;
            left_nxt  = left_fin;
          end else begin
            phase_nxt = PH_RDAT;
          end
        end
        PH_RDAT: begin
          if (b == esc_r) begin
            phase_nxt = PH_RCNT;
          end else if (woff_r >= SECTOR_BYTES) begin
            res_vld    = 1'b1;
            res.status = ST_OVERRUN;
            halted_nxt = 1'b1;
          end else begin
            res_vld   = 1'b1;
            coded_nxt = coded_dec;
            woff_nxt  = woff_r + 9'd1;
            if (coded_dec == 8'd0) begin
              phase_nxt      = PH_HDR0;
              left_nxt       = left_fin;
              res.sector_end = 1'b1;
              res.track_end  = te_fin;
            end
          end
        end
        PH_RCNT: begin
          rep_nxt   = b;
          phase_nxt = PH_RVAL;
        end
        PH_RVAL: begin
          res.run_length = {1'b0, rep_r};
          if (rep_r != 8'd0 && rep_end > {1'b0, SECTOR_BYTES}) begin
            res_vld    = 1'b1;
            res.status = ST_OVERRUN;
            halted_nxt = 1'b1;
          end else begin
            res_vld   = (rep_r != 8'd0);
            coded_nxt = coded_sub3;
            woff_nxt  = rep_end[8:0];
            if (coded_sub3 == 8'd0) begin
              phase_nxt      = PH_HDR0;
              left_nxt       = left_fin;
              res.sector_end = 1'b1;
              res.track_end  = te_fin;
            end else begin
              phase_nxt = PH_RDAT;
            end
          end
        end
        default: phase_nxt = PH_HDR0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HDR0;
      mode_r   <= 2'd0;
      track_r  <= 6'd0;
      sector_r <= 8'd0;
      left_r   <= 5'd0;
      woff_r   <= 9'd0;
      coded_r  <= 8'd0;
      esc_r    <= 8'd0;
      rep_r    <= 8'd0;
      halted_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      mode_r   <= mode_nxt;
      track_r  <= track_nxt;
      sector_r <= sector_nxt;
      left_r   <= left_nxt;
      woff_r   <= woff_nxt;
      coded_r  <= coded_nxt;
      esc_r    <= esc_nxt;
      rep_r    <= rep_nxt;
      halted_r <= halted_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_err_halts : assert property (@(posedge clk) disable iff (!rst_n)
    res_vld && res.status != ST_OK |=> halted_r)
    else $error("error result did not halt the decoder");

  a_halt_sticks : assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r)
    else $error("halt released without reset");

  a_track_end_sector_end : assert property (@(posedge clk) disable iff (!rst_n)
    res_vld && res.track_end |-> res.sector_end)
    else $error("track end without sector end");

  a_sector_end_hdr : assert property (@(posedge clk) disable iff (!rst_n)
    res_vld && res.sector_end |=> phase_r == PH_HDR0)
    else $error("sector end did not return to header");
`endif

endmodule

FILE: design/srle_out_stage.sv
// ----------------------------------------------------------------------------
// srle_out_stage
// result register driving the run channel
// ----------------------------------------------------------------------------
module srle_out_stage
  import srle_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  res_t  res,
  input  logic  res_vld,
  output logic  advance,
  output logic  out_valid,
  input  logic  out_ready,
  output res_t  out_res
);

  logic vld_r;
  logic vld_nxt;
  res_t res_r;

  assign advance = !vld_r || out_ready;

  always_comb begin
    vld_nxt = vld_r;
    if (advance) begin
      vld_nxt = res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_vld) begin
      res_r <= res;
    end
  end

  assign out_valid = vld_r;
  assign out_res   = res_r;

endmodule
